/* design/chunked_relocation_loader_top_macros.svh */
// ============================================================================
// Chunked relocation loader assertion macros
// Assertion forms used by the loader's back end RTL.
// ============================================================================
`ifndef CHUNKED_RELOCATION_LOADER_TOP_MACROS_SVH
`define CHUNKED_RELOCATION_LOADER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/crl_pkg.sv */
// ============================================================================
// Chunked relocation loader package
// Sizes, codes and types shared by the loader's front, queue and back.
// ============================================================================
package crl_pkg;

    localparam int MAX_CHUNKS = 8;
    localparam int ADDR_W     = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CUR_W      = $clog2(MAX_CHUNKS + 16);
    localparam int TOTAL_W    = 16 + ADDR_W;
    localparam int RAM_W      = 32;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_FIT   = 2'd1;
    localparam logic [1:0] OP_WORD  = 2'd2;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_FIT,
        KIND_WORD
    } t_kind;

    typedef enum logic [1:0] {
        FIT_ONE   = 2'd0,
        FIT_SPLIT = 2'd1,
        FIT_NONE  = 2'd2
    } t_fit_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIT,
        S_WORD
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [2:0]         index;
        logic [15:0]        size;
        logic [15:0]        base;
        logic [15:0]        words;
        logic signed [15:0] code_word;
        logic               relocate;
        logic               first_word;
        logic [CUR_W-1:0]   start_chunk;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [1:0]         fit_status;
        logic [2:0]         fit_chunk;
        logic signed [15:0] relocated_word;
        logic [2:0]         word_chunk;
        logic               overflow;
        logic               out_of_chunks;
    } t_result;

endpackage

/* design/crl_ram.sv */
// ============================================================================
// Generic single-port RAM
// One write or one read per cycle, with registered read data.
// ============================================================================
module crl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                           i_wdata,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/crl_front.sv */
// ============================================================================
// Chunked relocation loader front end
// Accepts items, drops those with no effect and builds queue commands.
// ============================================================================
module crl_front (
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_op,
    input  logic [2:0]           i_entry_index,
    input  logic [15:0]          i_entry_size,
    input  logic [15:0]          i_entry_base,
    input  logic [15:0]          i_program_words,
    input  logic signed [15:0]   i_code_word,
    input  logic                 i_relocate,
    input  logic                 i_first_word,
    input  logic [3:0]           i_start_mode,
    input  crl_pkg::t_q_status   i_q_status,
    output logic                 o_push,
    output crl_pkg::t_cmd        o_cmd
);

    logic w_keep;

    always_comb begin
        o_cmd.kind        = crl_pkg::KIND_WRITE;
        o_cmd.index       = i_entry_index;
        o_cmd.size        = i_entry_size;
        o_cmd.base        = i_entry_base;
        o_cmd.words       = i_program_words;
        o_cmd.code_word   = i_code_word;
        o_cmd.relocate    = i_relocate;
        o_cmd.first_word  = i_first_word;
        o_cmd.start_chunk = (i_start_mode != 4'd0) ?
                            crl_pkg::CUR_W'(i_start_mode - 4'd1) : '0;
        w_keep            = 1'b0;
        unique case (i_op)
            crl_pkg::OP_WRITE: begin
                o_cmd.kind = crl_pkg::KIND_WRITE;
                w_keep     = crl_pkg::CUR_W'(i_entry_index) <
                             crl_pkg::CUR_W'(crl_pkg::MAX_CHUNKS);
            end
            crl_pkg::OP_FIT: begin
                o_cmd.kind = crl_pkg::KIND_FIT;
                w_keep     = 1'b1;
            end
            crl_pkg::OP_WORD: begin
                o_cmd.kind = crl_pkg::KIND_WORD;
                w_keep     = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign busy   = i_q_status.full;
    assign o_push = start && !i_q_status.full && w_keep;

endmodule

/* design/crl_queue.sv */
// ============================================================================
// Chunked relocation loader command queue
// Short register FIFO between the front end and the back end.
// ============================================================================
module crl_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  crl_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output crl_pkg::t_cmd      o_head,
    output crl_pkg::t_q_status o_status
);

    crl_pkg::t_cmd                r_data [crl_pkg::Q_DEPTH];
    logic [crl_pkg::Q_PTR_W-1:0]  r_wptr, n_wptr;
    logic [crl_pkg::Q_PTR_W-1:0]  r_rptr, n_rptr;
    logic [crl_pkg::Q_CNT_W-1:0]  r_count, n_count;
    logic                         w_push, w_pop;

    assign w_push = i_push && (r_count != crl_pkg::Q_CNT_W'(crl_pkg::Q_DEPTH));
    assign w_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == crl_pkg::Q_PTR_W'(crl_pkg::Q_DEPTH - 1)) ?
                     '0 : crl_pkg::Q_PTR_W'(r_wptr + 1'b1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == crl_pkg::Q_PTR_W'(crl_pkg::Q_DEPTH - 1)) ?
                     '0 : crl_pkg::Q_PTR_W'(r_rptr + 1'b1);
        end
        if (w_push && !w_pop) begin
            n_count = crl_pkg::Q_CNT_W'(r_count + 1'b1);
        end else if (w_pop && !w_push) begin
            n_count = crl_pkg::Q_CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wptr] <= i_cmd;
        end
    end

    assign o_head         = r_data[r_rptr];
    assign o_status.full  = (r_count == crl_pkg::Q_CNT_W'(crl_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

/* design/crl_back.sv */
// ============================================================================
// Chunked relocation loader back end
// Holds the chunk table and placement state, runs fit scans and relocation.
// ============================================================================
`include "chunked_relocation_loader_top_macros.svh"

module crl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_write,
    input  logic [3:0]         i_cfg_data,
    input  crl_pkg::t_cmd      i_head,
    input  crl_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_done,
    output crl_pkg::t_result   o_result
);

    crl_pkg::t_state                r_state, n_state;
    logic [3:0]                     r_chunk_count;
    logic [crl_pkg::CUR_W-1:0]      r_cur, n_cur;
    logic [15:0]                    r_off, n_off;
    logic [crl_pkg::CUR_W-1:0]      r_k, n_k;
    logic [crl_pkg::TOTAL_W-1:0]    r_total, n_total;
    logic [15:0]                    r_need, n_need;
    logic signed [15:0]             r_code, n_code;
    logic                           r_reloc, n_reloc;
    logic                           r_done, n_done;
    crl_pkg::t_result               r_result, n_result;

    logic                           ram_we;
    logic [crl_pkg::ADDR_W-1:0]     ram_addr;
    logic [crl_pkg::RAM_W-1:0]      ram_wdata;
    logic [crl_pkg::RAM_W-1:0]      ram_rdata;
    logic [15:0]                    ram_size, ram_base;

    logic [crl_pkg::CUR_W-1:0]      w_n;
    logic                           w_take;
    logic [crl_pkg::CUR_W-1:0]      w_cur0;
    logic                           w_in0;
    logic                           w_full;
    logic [crl_pkg::CUR_W-1:0]      w_cur_nx;
    logic                           w_cur_nx_out;
    logic                           w_fit_hit;
    logic [crl_pkg::CUR_W-1:0]      w_k_nx;
    logic                           w_k_last;
    logic [crl_pkg::TOTAL_W-1:0]    w_total_nx;
    logic signed [16:0]             w_sum;

    crl_ram #(
        .WIDTH (crl_pkg::RAM_W),
        .DEPTH (crl_pkg::MAX_CHUNKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign ram_size  = ram_rdata[31:16];
    assign ram_base  = ram_rdata[15:0];
    assign ram_wdata = {i_head.size, i_head.base};

    assign w_n = (crl_pkg::CUR_W'(r_chunk_count) > crl_pkg::CUR_W'(crl_pkg::MAX_CHUNKS)) ?
                 crl_pkg::CUR_W'(crl_pkg::MAX_CHUNKS) : crl_pkg::CUR_W'(r_chunk_count);

    assign w_take       = (r_state == crl_pkg::S_IDLE) && !i_q_status.empty;
    assign w_cur0       = i_head.first_word ? i_head.start_chunk : r_cur;
    assign w_in0        = w_cur0 < w_n;
    assign w_full       = r_off >= ram_size;
    assign w_cur_nx     = crl_pkg::CUR_W'(r_cur + 1'b1);
    assign w_cur_nx_out = w_cur_nx >= w_n;
    assign w_fit_hit    = ram_size >= r_need;
    assign w_k_nx       = crl_pkg::CUR_W'(r_k + 1'b1);
    assign w_k_last     = w_k_nx >= w_n;
    assign w_total_nx   = r_total + crl_pkg::TOTAL_W'(ram_size);
    assign w_sum        = {r_code[15], r_code} + $signed({1'b0, ram_base});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crl_pkg::S_IDLE: begin
                if (w_take) begin
                    unique case (i_head.kind)
                        crl_pkg::KIND_FIT:  n_state = (w_n == '0) ? crl_pkg::S_IDLE
                                                                  : crl_pkg::S_FIT;
                        crl_pkg::KIND_WORD: n_state = w_in0 ? crl_pkg::S_WORD
                                                            : crl_pkg::S_IDLE;
                        default:            n_state = crl_pkg::S_IDLE;
                    endcase
                end
            end
            crl_pkg::S_FIT: begin
                if (w_fit_hit || w_k_last) begin
                    n_state = crl_pkg::S_IDLE;
                end
            end
            crl_pkg::S_WORD: begin
                if (!w_full || w_cur_nx_out) begin
                    n_state = crl_pkg::S_IDLE;
                end
            end
            default: n_state = crl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cur    = r_cur;
        n_off    = r_off;
        n_k      = r_k;
        n_total  = r_total;
        n_need   = r_need;
        n_code   = r_code;
        n_reloc  = r_reloc;
        n_done   = 1'b0;
        n_result = r_result;
        o_pop    = 1'b0;
        ram_we   = 1'b0;
        ram_addr = crl_pkg::ADDR_W'(r_cur);
        unique case (r_state)
            crl_pkg::S_IDLE: begin
                if (w_take) begin
                    o_pop = 1'b1;
                    unique case (i_head.kind)
                        crl_pkg::KIND_WRITE: begin
                            ram_we   = 1'b1;
                            ram_addr = crl_pkg::ADDR_W'(i_head.index);
                        end
                        crl_pkg::KIND_FIT: begin
                            n_need   = i_head.words;
                            n_k      = '0;
                            n_total  = '0;
                            ram_addr = '0;
                            if (w_n == '0) begin
                                n_done   = 1'b1;
                                n_result = '0;
                                n_result.fit_status = (i_head.words == 16'd0) ?
                                                      crl_pkg::FIT_SPLIT : crl_pkg::FIT_NONE;
                            end
                        end
                        crl_pkg::KIND_WORD: begin
                            n_code   = i_head.code_word;
                            n_reloc  = i_head.relocate;
                            n_cur    = w_cur0;
                            n_off    = i_head.first_word ? 16'd0 : r_off;
                            ram_addr = crl_pkg::ADDR_W'(w_cur0);
                            if (!w_in0) begin
                                n_done   = 1'b1;
                                n_result = '0;
                                n_result.relocated_word = i_head.code_word;
                                n_result.out_of_chunks  = 1'b1;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            crl_pkg::S_FIT: begin
                if (w_fit_hit) begin
                    n_done   = 1'b1;
                    n_result = '0;
                    n_result.fit_status = crl_pkg::FIT_ONE;
                    n_result.fit_chunk  = 3'(r_k);
                end else begin
                    n_total  = w_total_nx;
                    n_k      = w_k_nx;
                    ram_addr = crl_pkg::ADDR_W'(w_k_nx);
                    if (w_k_last) begin
                        n_done   = 1'b1;
                        n_result = '0;
                        n_result.fit_status = (w_total_nx < crl_pkg::TOTAL_W'(r_need)) ?
                                              crl_pkg::FIT_NONE : crl_pkg::FIT_SPLIT;
                    end
                end
            end
            crl_pkg::S_WORD: begin
                if (!w_full) begin
                    n_done   = 1'b1;
                    n_result = '0;
                    n_result.relocated_word = r_reloc ? w_sum[15:0] : r_code;
                    n_result.overflow       = r_reloc && (w_sum[16] != w_sum[15]);
                    n_result.word_chunk     = 3'(r_cur);
                    n_off                   = r_off + 16'd1;
                end else begin
                    n_off    = 16'd0;
                    n_cur    = w_cur_nx;
                    ram_addr = crl_pkg::ADDR_W'(w_cur_nx);
                    if (w_cur_nx_out) begin
                        n_done   = 1'b1;
                        n_result = '0;
                        n_result.relocated_word = r_code;
                        n_result.out_of_chunks  = 1'b1;
                    end
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= crl_pkg::S_IDLE;
            r_chunk_count <= 4'd1;
            r_cur         <= '0;
            r_off         <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_off   <= n_off;
            r_done  <= n_done;
            if (i_cfg_write) begin
                r_chunk_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_total  <= n_total;
        r_need   <= n_need;
        r_code   <= n_code;
        r_reloc  <= n_reloc;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `CRL_ASSERT_SAME(a_done_idle, r_done, r_state == crl_pkg::S_IDLE, "result while busy")
    `CRL_ASSERT_SAME(a_word_in_range, r_state == crl_pkg::S_WORD, r_cur < w_n, "chunk past end")
    `CRL_ASSERT_SAME(a_fit_in_range, r_state == crl_pkg::S_FIT, r_k < w_n, "scan past end")
    `CRL_ASSERT_SAME(a_ooc_clean, r_done && r_result.out_of_chunks, !r_result.overflow && (r_result.word_chunk == 3'd0), "bad out-of-chunks result")
    `CRL_ASSERT_NEXT(a_pop_leaves_idle, o_pop && (i_head.kind != crl_pkg::KIND_WRITE) && !n_done, r_state != crl_pkg::S_IDLE, "command lost")

endmodule

/* design/chunked_relocation_loader_top.sv */
// ============================================================================
// Chunked relocation loader
// First-fit chunk placement and word relocation over a table of chunks.
// ============================================================================
// Usage: an item is taken at a rising edge with start high and busy low.
// Op 0 loads one chunk table entry and gives no result. Op 1 asks whether
// a program of a given size fits; op 2 relocates one program word. Each of
// those gives one result, shown for one cycle with o_done high.
// The chunk count register is written through i_cfg_valid/o_cfg_ready;
// the user must write it only while the block is idle, which the block
// itself does not enforce. o_cfg_ready is always high. Items enter a
// two-entry command queue; busy is high while it is full.
// A code word walks the chunks, skipping each full or empty one in turn;
// a fit query scans from chunk 0 until one holds the program or the last
// chunk is read. A word that starts past the chunks and a query with no
// chunk in use end without a scan. The back end finishes each item, or a
// table write, before it takes the next; the single-port chunk table with
// its registered read paces these steps.
// Reset clears the queue, placement state and result strobe and sets the
// chunk count to 1; table entries hold garbage until written.
// Results cannot be held off: each is taken in the cycle it is shown.
// ============================================================================
module chunked_relocation_loader_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [2:0]         i_entry_index,
    input  logic [15:0]        i_entry_size,
    input  logic [15:0]        i_entry_base,
    input  logic [15:0]        i_program_words,
    input  logic signed [15:0] i_code_word,
    input  logic               i_relocate,
    input  logic               i_first_word,
    input  logic [3:0]         i_start_mode,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data,
    output logic               o_done,
    output logic [1:0]         o_fit_status,
    output logic [2:0]         o_fit_chunk,
    output logic signed [15:0] o_relocated_word,
    output logic [2:0]         o_word_chunk,
    output logic               o_overflow,
    output logic               o_out_of_chunks
);

    logic               push;
    logic               pop;
    crl_pkg::t_cmd      cmd;
    crl_pkg::t_cmd      head;
    crl_pkg::t_q_status q_status;
    crl_pkg::t_result   result;

    crl_front u_front (
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_entry_index   (i_entry_index),
        .i_entry_size    (i_entry_size),
        .i_entry_base    (i_entry_base),
        .i_program_words (i_program_words),
        .i_code_word     (i_code_word),
        .i_relocate      (i_relocate),
        .i_first_word    (i_first_word),
        .i_start_mode    (i_start_mode),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_cmd           (cmd)
    );

    crl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    crl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_done      (o_done),
        .o_result    (result)
    );

    assign o_cfg_ready      = 1'b1;
    assign o_fit_status     = result.fit_status;
    assign o_fit_chunk      = result.fit_chunk;
    assign o_relocated_word = result.relocated_word;
    assign o_word_chunk     = result.word_chunk;
    assign o_overflow       = result.overflow;
    assign o_out_of_chunks  = result.out_of_chunks;

endmodule

/* dv/tb_top.sv */
// ============================================================================
// Chunked relocation loader testbench
// Drives table writes, fit queries and code words into the loader, predicts
// every result with a behavioral copy of the chunk table and placement state,
// and checks each o_done beat field by field against the oldest prediction.
// The chunk count is changed between phases while the block is idle.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int          WORD_MAX     = 32767;
    localparam int          WORD_MIN     = -32768;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned PHASE_ITEMS  = 180;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         entry_index;
        logic [15:0]        entry_size;
        logic [15:0]        entry_base;
        logic [15:0]        program_words;
        logic signed [15:0] code_word;
        logic               relocate;
        logic               first_word;
        logic [3:0]         start_mode;
    } t_loader_item;

    class placement_checker;
        logic [15:0]      chunk_size [crl_pkg::MAX_CHUNKS];
        logic [15:0]      chunk_base [crl_pkg::MAX_CHUNKS];
        int unsigned      cur_chunk;
        int unsigned      word_offset;
        int unsigned      chunk_count;
        crl_pkg::t_result pending_results [$];
        int unsigned      errors;

        function new();
            cur_chunk   = 0;
            word_offset = 0;
            chunk_count = 1;
            errors      = 0;
        endfunction

        function void set_chunk_count(logic [3:0] value);
            chunk_count = value;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function int unsigned chunks_in_use();
            return (chunk_count > crl_pkg::MAX_CHUNKS) ? crl_pkg::MAX_CHUNKS : chunk_count;
        endfunction

        function void note_command(t_loader_item cmd);
            crl_pkg::t_result want;
            int unsigned      in_use;
            int unsigned      total;
            int unsigned      k;
            int               sum;
            bit               found;
            in_use = chunks_in_use();
            want   = '0;
            case (cmd.op)
                crl_pkg::OP_WRITE: begin
                    chunk_size[cmd.entry_index] = cmd.entry_size;
                    chunk_base[cmd.entry_index] = cmd.entry_base;
                end
                crl_pkg::OP_FIT: begin
                    total = 0;
                    found = 1'b0;
                    for (k = 0; k < in_use; k++) begin
                        if (!found) begin
                            if (chunk_size[k] >= cmd.program_words) begin
                                found          = 1'b1;
                                want.fit_status = crl_pkg::FIT_ONE;
                                want.fit_chunk  = 3'(k);
                            end else begin
                                total += chunk_size[k];
                            end
                        end
                    end
                    if (!found) begin
                        want.fit_status = (total < cmd.program_words) ?
                                          crl_pkg::FIT_NONE : crl_pkg::FIT_SPLIT;
                    end
                    pending_results.push_back(want);
                end
                crl_pkg::OP_WORD: begin
                    if (cmd.first_word) begin
                        cur_chunk   = (cmd.start_mode > 0) ? cmd.start_mode - 1 : 0;
                        word_offset = 0;
                    end
                    // Full chunks and chunks of size zero are passed over.
                    while (cur_chunk < in_use && word_offset >= chunk_size[cur_chunk]) begin
                        word_offset = 0;
                        cur_chunk++;
                    end
                    if (cur_chunk >= in_use) begin
                        want.relocated_word = cmd.code_word;
                        want.out_of_chunks  = 1'b1;
                    end else begin
                        if (cmd.relocate) begin
                            sum = int'(cmd.code_word) + int'(chunk_base[cur_chunk]);
                            want.overflow       = (sum > WORD_MAX) || (sum < WORD_MIN);
                            want.relocated_word = 16'(sum);
                        end else begin
                            want.relocated_word = cmd.code_word;
                        end
                        want.word_chunk = 3'(cur_chunk);
                        word_offset++;
                    end
                    pending_results.push_back(want);
                end
                default: begin
                end
            endcase
        endfunction

        function void log_failure(string what, crl_pkg::t_result want,
                                  crl_pkg::t_result got);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t %s: expected status=%0d chunk=%0d word=%h wchunk=%0d ",
                         $time, what, want.fit_status, want.fit_chunk,
                         want.relocated_word, want.word_chunk,
                         "ovf=%0b ooc=%0b; got status=%0d chunk=%0d word=%h wchunk=%0d ",
                         want.overflow, want.out_of_chunks, got.fit_status,
                         got.fit_chunk, got.relocated_word, got.word_chunk,
                         "ovf=%0b ooc=%0b", got.overflow, got.out_of_chunks);
            end
        endfunction

        function void check_result(crl_pkg::t_result got);
            crl_pkg::t_result want;
            if (pending_results.size() == 0) begin
                log_failure("unexpected result beat", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.fit_status !== want.fit_status || got.fit_chunk !== want.fit_chunk ||
                got.relocated_word !== want.relocated_word ||
                got.word_chunk !== want.word_chunk || got.overflow !== want.overflow ||
                got.out_of_chunks !== want.out_of_chunks) begin
                log_failure("result mismatch", want, got);
            end
        endfunction

        function void check_drained();
            if (pending_results.size() != 0) begin
                errors += pending_results.size();
                $display("%0t %0d expected results never arrived", $time,
                         pending_results.size());
            end
        endfunction
    endclass

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               start            = 1'b0;
    logic               busy;
    logic [1:0]         i_op             = '0;
    logic [2:0]         i_entry_index    = '0;
    logic [15:0]        i_entry_size     = '0;
    logic [15:0]        i_entry_base     = '0;
    logic [15:0]        i_program_words  = '0;
    logic signed [15:0] i_code_word      = '0;
    logic               i_relocate       = 1'b0;
    logic               i_first_word     = 1'b0;
    logic [3:0]         i_start_mode     = '0;
    logic               i_cfg_valid      = 1'b0;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_data       = '0;
    logic               o_done;
    logic [1:0]         o_fit_status;
    logic [2:0]         o_fit_chunk;
    logic signed [15:0] o_relocated_word;
    logic [2:0]         o_word_chunk;
    logic               o_overflow;
    logic               o_out_of_chunks;

    placement_checker   sb;
    int unsigned        idle_pct;
    int unsigned        cycle_count = 0;

    chunked_relocation_loader_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_entry_index    (i_entry_index),
        .i_entry_size     (i_entry_size),
        .i_entry_base     (i_entry_base),
        .i_program_words  (i_program_words),
        .i_code_word      (i_code_word),
        .i_relocate       (i_relocate),
        .i_first_word     (i_first_word),
        .i_start_mode     (i_start_mode),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_fit_status     (o_fit_status),
        .o_fit_chunk      (o_fit_chunk),
        .o_relocated_word (o_relocated_word),
        .o_word_chunk     (o_word_chunk),
        .o_overflow       (o_overflow),
        .o_out_of_chunks  (o_out_of_chunks)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        crl_pkg::t_result got;
        if (i_rst_n && o_done) begin
            got.fit_status     = o_fit_status;
            got.fit_chunk      = o_fit_chunk;
            got.relocated_word = o_relocated_word;
            got.word_chunk     = o_word_chunk;
            got.overflow       = o_overflow;
            got.out_of_chunks  = o_out_of_chunks;
            sb.check_result(got);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    function automatic t_loader_item random_item(logic [1:0] op);
        t_loader_item item;
        item.op            = op;
        item.entry_index   = 3'($urandom);
        item.entry_size    = 16'($urandom);
        item.entry_base    = 16'($urandom);
        item.program_words = 16'($urandom);
        item.code_word     = 16'($urandom);
        item.relocate      = 1'($urandom);
        item.first_word    = 1'($urandom);
        item.start_mode    = 4'($urandom);
        return item;
    endfunction

    task automatic issue_command(input t_loader_item item);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_op            <= item.op;
        i_entry_index   <= item.entry_index;
        i_entry_size    <= item.entry_size;
        i_entry_base    <= item.entry_base;
        i_program_words <= item.program_words;
        i_code_word     <= item.code_word;
        i_relocate      <= item.relocate;
        i_first_word    <= item.first_word;
        i_start_mode    <= item.start_mode;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        sb.note_command(item);
    endtask

    task automatic send_write(input logic [2:0] index, input logic [15:0] size,
                              input logic [15:0] base);
        t_loader_item item;
        item             = random_item(crl_pkg::OP_WRITE);
        item.entry_index = index;
        item.entry_size  = size;
        item.entry_base  = base;
        issue_command(item);
    endtask

    task automatic send_fit(input logic [15:0] words);
        t_loader_item item;
        item               = random_item(crl_pkg::OP_FIT);
        item.program_words = words;
        issue_command(item);
    endtask

    task automatic send_word(input logic [15:0] word, input logic relocate,
                             input logic first, input logic [3:0] mode);
        t_loader_item item;
        item            = random_item(crl_pkg::OP_WORD);
        item.code_word  = word;
        item.relocate   = relocate;
        item.first_word = first;
        item.start_mode = mode;
        issue_command(item);
    endtask

    // The block may still be busy on a table write after the last result.
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_chunk_count(input logic [3:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        sb.set_chunk_count(value);
    endtask

    function automatic logic [15:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return 16'($urandom_range(0, 5));
        if (r < 90) return 16'($urandom_range(0, 40));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_base();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) return 16'($urandom);
        if (r < 75) return 16'($urandom_range(16'h7F00, 16'hFFFF));
        return 16'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_need();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 16'($urandom_range(0, 12));
        if (r < 80) return 16'($urandom_range(0, 200));
        return 16'($urandom);
    endfunction

    task automatic run_random(input int unsigned target);
        int unsigned sent;
        int unsigned r;
        int unsigned len;
        int unsigned i;
        int unsigned in_use;
        logic        first;
        logic [3:0]  mode;
        sent = 0;
        while (sent < target) begin
            r = $urandom_range(99);
            if (r < 4) begin
                issue_command(random_item(OP_UNUSED));
            end else if (r < 12) begin
                send_write(3'($urandom), pick_size(), pick_base());
                sent++;
            end else if (r < 20) begin
                send_fit(pick_need());
                sent++;
            end else begin
                // A program: a first word and its followers, sometimes broken.
                len    = $urandom_range(1, 16);
                in_use = sb.chunks_in_use();
                for (i = 0; i < len; i++) begin
                    if (i == 0) begin
                        first = ($urandom_range(99) >= 10);
                    end else begin
                        first = ($urandom_range(99) < 3);
                    end
                    if ($urandom_range(99) < 80) begin
                        mode = 4'($urandom_range(0, in_use + 1));
                    end else begin
                        mode = 4'($urandom_range(0, 15));
                    end
                    send_word(16'($urandom), 1'($urandom), first, mode);
                end
                sent += len;
            end
        end
    endtask

    initial begin
        logic [3:0]   phase_count [6];
        int unsigned  ph;
        t_loader_item noise;
        phase_count = '{4'd1, 4'd15, 4'd3, 4'd0, 4'd8, 4'd6};
        sb       = new();
        idle_pct = 38;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One chunk in use after reset; unknown op with every bit set.
        noise = '1;
        issue_command(noise);
        send_write(3'd0, 16'd2, 16'h7FFF);
        send_write(3'd1, 16'd0, 16'h0000);
        send_write(3'd2, 16'd1, 16'h8000);
        send_write(3'd3, 16'd3, 16'h0001);
        send_write(3'd4, 16'hFFFF, 16'hFFFF);
        send_write(3'd5, 16'd1, 16'h0100);
        send_write(3'd6, 16'd0, 16'h1234);
        send_write(3'd7, 16'd2, 16'h00FF);
        send_fit(16'd2);
        send_fit(16'd3);
        send_word(16'h0001, 1'b1, 1'b1, 4'd0);

        settle();
        write_chunk_count(4'd8);
        send_fit(16'd0);
        send_fit(16'd3);
        send_fit(16'hFFFF);
        send_word(16'h7FFF, 1'b1, 1'b1, 4'd0);
        send_word(16'hFFFF, 1'b1, 1'b0, 4'd0);
        send_word(16'h8000, 1'b1, 1'b0, 4'd0);
        send_word(16'h1234, 1'b0, 1'b0, 4'd0);
        send_word(16'h0042, 1'b1, 1'b1, 4'd8);
        send_word(16'h0042, 1'b1, 1'b1, 4'd15);
        send_word(16'h0043, 1'b1, 1'b0, 4'd0);

        // No chunk in use at all.
        settle();
        write_chunk_count(4'd0);
        send_fit(16'd0);
        send_fit(16'd1);
        send_word(16'h5555, 1'b1, 1'b1, 4'd0);

        for (ph = 0; ph < 6; ph++) begin
            idle_pct = (ph < 2) ? 38 : (ph < 4) ? 45 : 0;
            settle();
            write_chunk_count(phase_count[ph]);
            run_random(PHASE_ITEMS);
        end

        settle();
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
